// ===== rtl/lsci_pkg.sv =====
// Shared constants, types and ROM build functions for the sine/cosine interpolator.
`timescale 1ns / 1ps

package lsci_pkg;

    // Table geometry
    localparam int TABLE_INTERVALS = 1024;
    localparam int IDX_W           = $clog2(TABLE_INTERVALS);
    localparam int ADDR_W          = $clog2(TABLE_INTERVALS + 1);

    // Field widths
    localparam int ANGLE_W  = 18;
    localparam int VALUE_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int OFFSET_W = ANGLE_W;
    localparam int POS_W    = IDX_W + FRAC_W;

    // Angle constants: pi in Q3.15 and in Q30
    localparam int                PI_Q15     = 102944;
    localparam int                ANGLE_SPAN = 2 * PI_Q15;
    localparam longint unsigned   PI_Q30     = 64'd3373259426;
    localparam longint unsigned   TWO_N      = 2 * TABLE_INTERVALS;

    // Position = floor(offset * KNUM / ANGLE_SPAN), done as a multiply by a
    // truncated reciprocal followed by a single correction step.
    localparam longint unsigned KNUM        = longint'(TABLE_INTERVALS) << FRAC_W;
    localparam int              RECIP_SHIFT = OFFSET_W;
    localparam longint unsigned RECIP       = (KNUM << RECIP_SHIFT) / ANGLE_SPAN;
    localparam int              RECIP_W     = $clog2(RECIP + 1);
    localparam int              FRONT_PROD_W = OFFSET_W + RECIP_W;
    localparam int              REM_W       = $clog2(2 * ANGLE_SPAN);

    // Interpolation arithmetic
    localparam int DIFF_W    = VALUE_W + 1;
    localparam int IP_W      = FRAC_W + 1 + DIFF_W;
    localparam int SUM_W     = VALUE_W + 2;
    localparam int HALF_LSB  = 1 << (FRAC_W - 1);
    localparam int VALUE_MAX = 2 ** (VALUE_W - 1) - 1;
    localparam int VALUE_MIN = -(2 ** (VALUE_W - 1));

    // Decoupling queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CREDIT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_MID  = 2'b00,
        CLS_LOW  = 2'b01,
        CLS_HIGH = 2'b10
    } angle_class_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
        logic [FRAC_W-1:0] frac;
    } lsci_job_t;

    typedef logic signed [VALUE_W-1:0] rom_t [0:TABLE_INTERVALS];

    // Q15 sine of pi * b / (2 * TABLE_INTERVALS), odd Taylor series to x^19 in Q30.
    function automatic logic signed [VALUE_W-1:0] sin_half_units(input longint b);
        longint          n;
        longint          bb;
        logic            neg;
        longint unsigned mag;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        n  = longint'(TABLE_INTERVALS);
        bb = b;
        if (bb > 2 * n) bb = bb - 4 * n;
        if (bb > n) bb = 2 * n - bb;
        else if (bb < -n) bb = -2 * n - bb;
        neg = (bb < 0);
        if (neg) mag = $unsigned(-bb);
        else mag = $unsigned(bb);
        x    = (PI_Q30 * mag) / TWO_N;
        x2   = (x * x) >> 30;
        sum  = $signed(x);
        term = x;
        term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 272; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 342; sum = sum - $signed(term);
        if (sum < 0) sum = 0;
        q = $signed(($unsigned(sum) + 64'd16384) >> 15);
        if (neg) q = -q;
        if (q > VALUE_MAX) q = VALUE_MAX;
        if (q < VALUE_MIN) q = VALUE_MIN;
        return VALUE_W'(q);
    endfunction

    // Samples at -pi + 2*pi*i/TABLE_INTERVALS; cosine is sine a quarter turn on.
    function automatic rom_t build_rom(input logic cos_sel);
        rom_t   rom;
        longint b;
        for (int i = 0; i <= TABLE_INTERVALS; i++) begin
            b = 4 * longint'(i) - 2 * longint'(TABLE_INTERVALS);
            if (cos_sel) b = b + longint'(TABLE_INTERVALS);
            rom[i] = sin_half_units(b);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/lsci_front.sv =====
// Front end: accepts angles, classifies them and maps them to table addresses and fraction.
`timescale 1ns / 1ps

module lsci_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [lsci_pkg::ANGLE_W-1:0] s_angle,
    output logic                                push,
    output lsci_pkg::lsci_job_t                 push_job,
    input  logic                                pop
);
    import lsci_pkg::*;

    logic                          accept;
    logic signed [ANGLE_W:0]       shifted;
    angle_class_t                  in_cls;
    logic [CREDIT_W-1:0]           used_reg;
    logic [CREDIT_W-1:0]           used_next;

    logic                          f0_valid_reg;
    logic                          f0_cmd_reg;
    angle_class_t                  f0_cls_reg;
    logic [OFFSET_W-1:0]           f0_offset_reg;

    logic                          f1_valid_reg;
    logic                          f1_cmd_reg;
    angle_class_t                  f1_cls_reg;
    logic [FRONT_PROD_W-1:0]       f1_prod_reg;
    logic [REM_W-1:0]              f1_lowk_reg;
    logic [POS_W-1:0]              q_est;

    logic                          f2_valid_reg;
    logic                          f2_cmd_reg;
    angle_class_t                  f2_cls_reg;
    logic [POS_W-1:0]              f2_qest_reg;
    logic [REM_W-1:0]              f2_qd_reg;
    logic [REM_W-1:0]              f2_lowk_reg;

    logic [REM_W-1:0]              rem;
    logic [POS_W-1:0]              pos;
    logic [IDX_W-1:0]              idx;
    logic [ADDR_W-1:0]             idx_c;

    assign accept = s_valid && s_ready;
    // Credit covers everything accepted but not yet taken out of the queue.
    assign s_ready   = (used_reg < CREDIT_W'(QUEUE_DEPTH));
    assign used_next = used_reg + CREDIT_W'(accept) - CREDIT_W'(pop);

    assign shifted = (ANGLE_W + 1)'(s_angle) + (ANGLE_W + 1)'(PI_Q15);

    always_comb begin
        if (shifted[ANGLE_W] || (shifted == '0)) begin
            in_cls = CLS_LOW;
        end else if (shifted >= $signed((ANGLE_W + 1)'(ANGLE_SPAN))) begin
            in_cls = CLS_HIGH;
        end else begin
            in_cls = CLS_MID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            used_reg     <= used_next;
            f0_valid_reg <= accept;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    assign q_est = POS_W'(f1_prod_reg >> RECIP_SHIFT);

    always_ff @(posedge aclk) begin
        f0_cmd_reg    <= s_command;
        f0_cls_reg    <= in_cls;
        f0_offset_reg <= shifted[OFFSET_W-1:0];

        f1_cmd_reg    <= f0_cmd_reg;
        f1_cls_reg    <= f0_cls_reg;
        f1_prod_reg   <= FRONT_PROD_W'(f0_offset_reg) * FRONT_PROD_W'(RECIP);
        f1_lowk_reg   <= REM_W'(f0_offset_reg) * REM_W'(KNUM);

        f2_cmd_reg    <= f1_cmd_reg;
        f2_cls_reg    <= f1_cls_reg;
        f2_qest_reg   <= q_est;
        f2_qd_reg     <= REM_W'(q_est) * REM_W'(ANGLE_SPAN);
        f2_lowk_reg   <= f1_lowk_reg;
    end

    // The estimate is exact or one short; the low bits of the remainder tell which.
    assign rem   = f2_lowk_reg - f2_qd_reg;
    assign pos   = f2_qest_reg + POS_W'(rem >= REM_W'(ANGLE_SPAN));
    assign idx   = pos[POS_W-1:FRAC_W];
    assign idx_c = (ADDR_W'(idx) >= ADDR_W'(TABLE_INTERVALS)) ?
                   ADDR_W'(TABLE_INTERVALS - 1) : ADDR_W'(idx);

    assign push = f2_valid_reg;

    always_comb begin
        push_job.cmd = f2_cmd_reg;
        case (f2_cls_reg)
            CLS_LOW: begin
                push_job.addr0 = '0;
                push_job.addr1 = '0;
                push_job.frac  = '0;
            end
            CLS_HIGH: begin
                push_job.addr0 = ADDR_W'(TABLE_INTERVALS);
                push_job.addr1 = ADDR_W'(TABLE_INTERVALS);
                push_job.frac  = '0;
            end
            CLS_MID: begin
                push_job.addr0 = idx_c;
                push_job.addr1 = idx_c + ADDR_W'(1);
                push_job.frac  = pos[FRAC_W-1:0];
            end
            default: begin
                push_job.addr0 = '0;
                push_job.addr1 = '0;
                push_job.frac  = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((push_job.addr1 == push_job.addr0) ||
                  (push_job.addr1 == push_job.addr0 + ADDR_W'(1))) &&
                 (push_job.addr1 <= ADDR_W'(TABLE_INTERVALS)))
        else $error("Table addresses are not neighbours within the table.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (push_job.addr0 == push_job.addr1)) |-> (push_job.frac == '0))
        else $error("Clamped angle carries a non-zero fraction.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (f2_valid_reg && (f2_cls_reg == CLS_MID)) |-> (rem < REM_W'(2 * ANGLE_SPAN)))
        else $error("Reciprocal estimate is off by more than one.");
`endif

endmodule

// ===== rtl/lsci_queue.sv =====
// Short queue that carries mapped jobs from the front end to the back end.
`timescale 1ns / 1ps

module lsci_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lsci_pkg::lsci_job_t push_job,
    input  logic                pop,
    output lsci_pkg::lsci_job_t head_job,
    output logic                empty
);
    import lsci_pkg::*;

    lsci_job_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [CREDIT_W-1:0] count_reg;
    logic [CREDIT_W-1:0] count_next;
    logic                full;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CREDIT_W'(QUEUE_DEPTH));
    assign head_job   = mem_reg[rd_ptr_reg];
    assign count_next = count_reg + CREDIT_W'(push) - CREDIT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("Job written into a full queue.");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("Job taken from an empty queue.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        QPTR_W'(count_reg) == QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("Queue fill count disagrees with its pointers.");
`endif

endmodule

// ===== rtl/lsci_back.sv =====
// Back end: ROM lookup of both neighbouring samples, interpolation and output register.
`timescale 1ns / 1ps

module lsci_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lsci_pkg::lsci_job_t                 head_job,
    input  logic                                q_empty,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lsci_pkg::VALUE_W-1:0] m_value
);
    import lsci_pkg::*;

    localparam rom_t SIN_ROM = build_rom(1'b0);
    localparam rom_t COS_ROM = build_rom(1'b1);

    logic                      en;
    logic                      b0_valid_reg;
    logic                      b1_valid_reg;
    logic                      m_valid_reg;
    logic                      b0_cmd_reg;
    logic [FRAC_W-1:0]         b0_frac_reg;
    logic signed [VALUE_W-1:0] b0_sin0_reg;
    logic signed [VALUE_W-1:0] b0_sin1_reg;
    logic signed [VALUE_W-1:0] b0_cos0_reg;
    logic signed [VALUE_W-1:0] b0_cos1_reg;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [FRAC_W:0]    frac_s;
    logic signed [IP_W-1:0]    b1_ip_reg;
    logic signed [VALUE_W-1:0] b1_base_reg;
    logic signed [IP_W-1:0]    ip_rnd;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] sat;
    logic signed [VALUE_W-1:0] m_value_reg;

    // The whole back pipeline moves when the output register is free or being taken.
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            b0_valid_reg <= !q_empty;
            b1_valid_reg <= b0_valid_reg;
            m_valid_reg  <= b1_valid_reg;
        end
    end

    assign lo     = b0_cmd_reg ? b0_cos0_reg : b0_sin0_reg;
    assign hi     = b0_cmd_reg ? b0_cos1_reg : b0_sin1_reg;
    assign diff   = DIFF_W'(hi) - DIFF_W'(lo);
    assign frac_s = $signed({1'b0, b0_frac_reg});

    assign ip_rnd = b1_ip_reg + $signed(IP_W'(HALF_LSB));
    assign sum    = SUM_W'(ip_rnd >>> FRAC_W) + SUM_W'(b1_base_reg);

    always_comb begin
        if (sum > $signed(SUM_W'(VALUE_MAX))) begin
            sat = VALUE_W'(VALUE_MAX);
        end else if (sum < $signed(SUM_W'(VALUE_MIN))) begin
            sat = VALUE_W'(VALUE_MIN);
        end else begin
            sat = VALUE_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b0_cmd_reg  <= head_job.cmd;
            b0_frac_reg <= head_job.frac;
            b0_sin0_reg <= SIN_ROM[head_job.addr0];
            b0_sin1_reg <= SIN_ROM[head_job.addr1];
            b0_cos0_reg <= COS_ROM[head_job.addr0];
            b0_cos1_reg <= COS_ROM[head_job.addr1];
            b1_ip_reg   <= IP_W'(frac_s * diff);
            b1_base_reg <= lo;
            m_value_reg <= sat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

endmodule

// ===== rtl/lut_sine_cosine_interp.sv =====
// Top level of the table-based sine/cosine unit with linear interpolation.
`timescale 1ns / 1ps

// Sine or cosine of a signed Q3.15 angle in radians, one result beat for every input
// beat, in order. The command bit picks sine (0) or cosine (1). Angles at or below -pi
// return the first table sample and angles at or above pi the last; any other angle is
// mapped onto 1024 intervals over [-pi, pi], and the Q1.15 result is the rounded linear
// interpolation between the two neighbouring samples of a built-in 1025-entry ROM, with
// +1.0 saturated to 32767. The unit takes one beat per clock cycle while s_ready
// is high. When the result side never stalls, a beat accepted at the input passes
// through the front end (classification, reciprocal multiply, correction), the job
// queue and the back end (ROM read, interpolation multiply, rounding and saturation
// into the output register) before it appears on m_value. The front end runs without
// stalling and holds a credit for every beat it has accepted until the back end takes
// it from the eight-entry queue, so s_ready only falls once eight accepted beats wait
// in the front end or the queue, which needs m_ready low. There are no configuration
// registers and no start-up sweep: the ROM contents are constant.

module lut_sine_cosine_interp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic signed [lsci_pkg::ANGLE_W-1:0] s_angle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lsci_pkg::VALUE_W-1:0] m_value
);
    import lsci_pkg::*;

    // Jobs leave the front end fully resolved: both table addresses and the fraction.
    logic      push;
    lsci_job_t push_job;
    logic      pop;
    lsci_job_t head_job;
    logic      q_empty;

    lsci_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_angle   (s_angle),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop)
    );

    lsci_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    lsci_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value)
    );

endmodule
